[rtl/core/rrr_pkg.sv]
// rrr_pkg: shared types, codes and helper functions of the rational rescale unit
// no dependencies; used by every module under rtl/core
package rrr_pkg;

    localparam int unsigned W  = 64;
    localparam int unsigned W2 = 128;

    localparam logic [7:0] DIV_ITER_WIDE   = 8'd128;
    localparam logic [7:0] DIV_ITER_NARROW = 8'd64;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ARG   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_REMAINDER = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;

    // automatic denominator modes; the spare code acts as exact
    localparam logic [1:0] DM_EXACT  = 2'd0;
    localparam logic [1:0] DM_REDUCE = 2'd1;
    localparam logic [1:0] DM_FIXED  = 2'd2;
    localparam logic [1:0] DM_SPARE  = 2'd3;

    // rounding modes
    localparam logic [2:0] RM_FLOOR     = 3'd0;
    localparam logic [2:0] RM_CEIL      = 3'd1;
    localparam logic [2:0] RM_TRUNC     = 3'd2;
    localparam logic [2:0] RM_PROMOTE   = 3'd3;
    localparam logic [2:0] RM_HALF_DOWN = 3'd4;
    localparam logic [2:0] RM_HALF_UP   = 3'd5;
    localparam logic [2:0] RM_HALF_EVEN = 3'd6;
    localparam logic [2:0] RM_NEVER     = 3'd7;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_ERR,
        DP_PASS,
        DP_ZERO,
        DP_GCD_RED,
        DP_GCD_SCL,
        DP_GCD_DIV,
        DP_GCD_NEXT,
        DP_RED_N,
        DP_RED_D,
        DP_RED_SAVE,
        DP_MUL_AD,
        DP_SAVE_A,
        DP_SET_A,
        DP_MUL_M,
        DP_SAVE_M,
        DP_DIV_Q,
        DP_DIV_M,
        DP_DIV_TG,
        DP_MUL_P,
        DP_SAVE_P,
        DP_FIN1,
        DP_FIN2,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic d_zero;
        logic t_zero;
        logic d_neg;
        logic t_neg;
        logic d_eq_t;
        logic n_zero;
        logic dm_fixed;
        logic dm_reduce;
        logic gb_zero;
        logic a_hi_nz;
        logic mul_done;
        logic div_done;
    } t_stat;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
    endfunction

    function automatic logic [W-1:0] f_sign(input logic [W-1:0] m, input logic neg);
        return neg ? (~m + {{(W-1){1'b0}}, 1'b1}) : m;
    endfunction

endpackage

[rtl/core/rrr_mul.sv]
// rrr_mul: 64x64 unsigned multiplier built from four 32x32 partial products
// depends on rrr_pkg
module rrr_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rrr_pkg::W-1:0]   i_x,
    input  logic [rrr_pkg::W-1:0]   i_y,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [rrr_pkg::W2-1:0]  o_p
);

    logic [rrr_pkg::W-1:0]  r_x, r_y;
    logic [rrr_pkg::W2-1:0] r_acc;
    logic [rrr_pkg::W-1:0]  r_pp;
    logic [1:0]             r_k, r_pk;
    logic                   r_run, r_pv, r_done;
    logic [31:0]            xs, ys;
    logic [rrr_pkg::W2-1:0] addend;

    always_comb begin
        xs = r_k[1] ? r_x[63:32] : r_x[31:0];
        ys = r_k[0] ? r_y[63:32] : r_y[31:0];
    end

    always_comb begin
        case (r_pk)
            2'd0:    addend = {64'd0, r_pp};
            2'd3:    addend = {r_pp, 64'd0};
            default: addend = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= r_pv && (r_pk == 2'd3);
            if (i_start) begin
                r_run <= 1'b1;
                r_pv  <= 1'b0;
                r_k   <= 2'd0;
            end else begin
                r_pv <= r_run;
                if (r_run) begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_run <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else begin
            if (r_run) begin
                r_pp <= {32'd0, xs} * {32'd0, ys};
                r_pk <= r_k;
            end
            if (r_pv) begin
                r_acc <= r_acc + addend;
            end
        end
    end

    assign o_busy = r_run | r_pv;
    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

[rtl/core/rrr_div.sv]
// rrr_div: restoring divider, one quotient bit a cycle, 128 or 64 iterations
// depends on rrr_pkg
module rrr_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_wide,
    input  logic [rrr_pkg::W2-1:0]  i_dividend,
    input  logic [rrr_pkg::W2-1:0]  i_divisor,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [rrr_pkg::W2-1:0]  o_q,
    output logic [rrr_pkg::W2-1:0]  o_r
);

    logic [rrr_pkg::W2-1:0] r_dvd, r_rem, r_quo, r_dvs;
    logic [7:0]             r_cnt;
    logic                   r_done;
    logic [rrr_pkg::W2-1:0] rem_sh;
    logic [rrr_pkg::W2:0]   diff;
    logic                   ge;

    always_comb begin
        rem_sh = {r_rem[rrr_pkg::W2-2:0], r_dvd[rrr_pkg::W2-1]};
        diff   = {1'b0, rem_sh} - {1'b0, r_dvs};
        // a carry out of the shift means the partial remainder exceeds any divisor
        ge     = r_rem[rrr_pkg::W2-1] | ~diff[rrr_pkg::W2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 8'd0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_wide ? rrr_pkg::DIV_ITER_WIDE : rrr_pkg::DIV_ITER_NARROW;
            r_done <= 1'b0;
        end else if (r_cnt != 8'd0) begin
            r_cnt  <= r_cnt - 8'd1;
            r_done <= (r_cnt == 8'd1);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_wide ? i_dividend : {i_dividend[rrr_pkg::W-1:0], 64'd0};
            r_rem <= '0;
            r_quo <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != 8'd0) begin
            r_dvd <= {r_dvd[rrr_pkg::W2-2:0], 1'b0};
            r_rem <= ge ? diff[rrr_pkg::W2-1:0] : rem_sh;
            r_quo <= {r_quo[rrr_pkg::W2-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != 8'd0);
    assign o_done = r_done;
    assign o_q    = r_quo;
    assign o_r    = r_rem;

endmodule

[rtl/core/rrr_datapath.sv]
// rrr_datapath: operand registers, gcd and scaling arithmetic, rounding, result register
// depends on rrr_pkg, rrr_mul, rrr_div
module rrr_datapath #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rrr_pkg::t_cmd              i_cmd,
    input  logic signed [63:0]         i_in_num,
    input  logic signed [63:0]         i_in_denom,
    input  logic signed [63:0]         i_target_denom,
    input  logic [1:0]                 i_denom_mode,
    input  logic [2:0]                 i_round_mode,
    output rrr_pkg::t_stat             o_stat,
    output logic signed [63:0]         o_out_num,
    output logic signed [63:0]         o_out_denom,
    output logic [2:0]                 o_status
);

    localparam logic [63:0] LimNeg = 64'd1 << (VALUE_BITS - 1);
    localparam logic [63:0] LimPos = LimNeg - 64'd1;

    logic [63:0]  r_n, r_d, r_t, r_an, r_dd, r_ga, r_gb, r_q64;
    logic [1:0]   r_dm;
    logic [2:0]   r_rm;
    logic         r_nneg, r_fit1, r_rnz, r_gt, r_eq;
    logic [127:0] r_a, r_m;
    logic [63:0]  r_res_num, r_res_den;
    logic [2:0]   r_res_st;
    logic [63:0]  r_o_num, r_o_den;
    logic [2:0]   r_o_st;

    logic         mul_start, mul_busy, mul_done;
    logic [63:0]  mul_x, mul_y;
    logic [127:0] mul_p;
    logic         div_start, div_wide, div_busy, div_done;
    logic [127:0] div_n, div_dv, div_q, div_r;

    logic [63:0]  lim;
    logic         up;
    logic [63:0]  fin_num, fin_den;
    logic [2:0]   fin_st;

    rrr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    rrr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_wide     (div_wide),
        .i_dividend (div_n),
        .i_divisor  (div_dv),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_q        (div_q),
        .o_r        (div_r)
    );

    always_comb begin
        mul_start = 1'b0;
        mul_x     = r_an;
        mul_y     = rrr_pkg::f_mag(r_d);
        div_start = 1'b0;
        div_wide  = 1'b0;
        div_n     = {64'd0, r_an};
        div_dv    = {64'd0, r_ga};
        case (i_cmd.op)
            rrr_pkg::DP_MUL_AD: begin
                mul_start = 1'b1;
            end
            rrr_pkg::DP_MUL_M: begin
                mul_start = 1'b1;
                mul_x     = r_dd;
                mul_y     = rrr_pkg::f_mag(r_t);
            end
            rrr_pkg::DP_MUL_P: begin
                mul_start = 1'b1;
                mul_x     = r_a[63:0];
                mul_y     = div_q[63:0];
            end
            rrr_pkg::DP_GCD_DIV: begin
                div_start = 1'b1;
                div_n     = {64'd0, r_ga};
                div_dv    = {64'd0, r_gb};
            end
            rrr_pkg::DP_RED_N: begin
                div_start = 1'b1;
            end
            rrr_pkg::DP_RED_D: begin
                div_start = 1'b1;
                div_n     = {64'd0, r_d};
            end
            rrr_pkg::DP_DIV_M: begin
                div_start = 1'b1;
                div_n     = {64'd0, r_dd};
            end
            rrr_pkg::DP_DIV_TG: begin
                div_start = 1'b1;
                div_n     = {64'd0, r_t};
            end
            rrr_pkg::DP_DIV_Q: begin
                div_start = 1'b1;
                div_wide  = 1'b1;
                div_n     = r_a;
                div_dv    = r_m;
            end
            default: begin
            end
        endcase
    end

    // final rounding on the registered quotient magnitude
    always_comb begin
        lim = r_nneg ? LimNeg : LimPos;
        case (r_rm)
            rrr_pkg::RM_FLOOR:     up = r_nneg;
            rrr_pkg::RM_CEIL:      up = ~r_nneg;
            rrr_pkg::RM_TRUNC:     up = 1'b0;
            rrr_pkg::RM_PROMOTE:   up = 1'b1;
            rrr_pkg::RM_HALF_DOWN: up = r_gt;
            rrr_pkg::RM_HALF_UP:   up = r_gt | r_eq;
            rrr_pkg::RM_HALF_EVEN: up = r_gt | (r_eq & r_q64[0]);
            default:               up = 1'b0;
        endcase
        up      = up & r_rnz;
        fin_num = 64'd0;
        fin_den = 64'd0;
        if (!r_fit1) begin
            fin_st = rrr_pkg::ST_OVERFLOW;
        end else if (r_rnz && r_rm == rrr_pkg::RM_NEVER) begin
            fin_st = rrr_pkg::ST_REMAINDER;
        end else if (up && r_q64 == lim) begin
            fin_st = rrr_pkg::ST_OVERFLOW;
        end else begin
            fin_st  = rrr_pkg::ST_OK;
            fin_num = rrr_pkg::f_sign(r_q64 + {63'd0, up}, r_nneg);
            fin_den = r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rrr_pkg::DP_LOAD: begin
                r_n    <= i_in_num;
                r_d    <= i_in_denom;
                r_t    <= i_target_denom;
                r_dm   <= i_denom_mode;
                r_rm   <= i_round_mode;
                r_an   <= rrr_pkg::f_mag(i_in_num);
                r_nneg <= i_in_num[63];
            end
            rrr_pkg::DP_ERR: begin
                r_res_num <= 64'd0;
                r_res_den <= 64'd0;
                r_res_st  <= i_cmd.code;
            end
            rrr_pkg::DP_PASS: begin
                r_res_num <= r_n;
                r_res_den <= r_d;
                r_res_st  <= rrr_pkg::ST_OK;
            end
            rrr_pkg::DP_ZERO: begin
                r_res_num <= 64'd0;
                r_res_den <= r_t;
                r_res_st  <= rrr_pkg::ST_OK;
            end
            rrr_pkg::DP_GCD_RED: begin
                r_ga <= r_an;
                r_gb <= r_d;
            end
            rrr_pkg::DP_GCD_SCL: begin
                r_ga <= r_t;
                r_gb <= r_dd;
            end
            rrr_pkg::DP_GCD_NEXT: begin
                r_ga <= r_gb;
                r_gb <= div_r[63:0];
            end
            rrr_pkg::DP_RED_D: begin
                r_res_num <= rrr_pkg::f_sign(div_q[63:0], r_nneg);
            end
            rrr_pkg::DP_RED_SAVE: begin
                r_res_den <= div_q[63:0];
                r_res_st  <= rrr_pkg::ST_OK;
            end
            rrr_pkg::DP_SAVE_A: begin
                r_a  <= mul_p;
                r_dd <= 64'd1;
            end
            rrr_pkg::DP_SET_A: begin
                r_a  <= {64'd0, r_an};
                r_dd <= r_d;
            end
            rrr_pkg::DP_SAVE_M: begin
                r_m <= mul_p;
            end
            rrr_pkg::DP_DIV_TG: begin
                r_m <= {64'd0, div_q[63:0]};
            end
            rrr_pkg::DP_SAVE_P: begin
                r_a <= mul_p;
            end
            rrr_pkg::DP_FIN1: begin
                r_q64  <= div_q[63:0];
                r_fit1 <= (div_q[127:64] == 64'd0) && (div_q[63:0] <= lim);
                r_rnz  <= (div_r != 128'd0);
                // twice the remainder against the divisor
                r_gt   <= {div_r, 1'b0} > {1'b0, r_m};
                r_eq   <= {div_r, 1'b0} == {1'b0, r_m};
            end
            rrr_pkg::DP_FIN2: begin
                r_res_num <= fin_num;
                r_res_den <= fin_den;
                r_res_st  <= fin_st;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_num <= 64'd0;
            r_o_den <= 64'd0;
            r_o_st  <= rrr_pkg::ST_OK;
        end else if (i_cmd.op == rrr_pkg::DP_EMIT) begin
            r_o_num <= r_res_num;
            r_o_den <= r_res_den;
            r_o_st  <= r_res_st;
        end
    end

    always_comb begin
        o_stat.d_zero    = (r_d == 64'd0);
        o_stat.t_zero    = (r_t == 64'd0);
        o_stat.d_neg     = r_d[63];
        o_stat.t_neg     = r_t[63];
        o_stat.d_eq_t    = (r_d == r_t);
        o_stat.n_zero    = (r_n == 64'd0);
        o_stat.dm_fixed  = (r_dm == rrr_pkg::DM_FIXED);
        o_stat.dm_reduce = (r_dm == rrr_pkg::DM_REDUCE);
        o_stat.gb_zero   = (r_gb == 64'd0);
        o_stat.a_hi_nz   = (r_a[127:64] != 64'd0);
        o_stat.mul_done  = mul_done;
        o_stat.div_done  = div_done;
    end

    assign o_out_num   = r_o_num;
    assign o_out_denom = r_o_den;
    assign o_status    = r_o_st;

`ifndef ASSERT_OFF
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_st != rrr_pkg::ST_OK) |-> (r_o_num == 64'd0 && r_o_den == 64'd0))
        else $error("error result with nonzero fraction");
`endif

endmodule

[rtl/core/rrr_ctrl.sv]
// rrr_ctrl: sequencer for the rescale unit, issues datapath commands
// depends on rrr_pkg
module rrr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  rrr_pkg::t_stat i_stat,
    output rrr_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WAIT_MA, S_SCALE, S_WAIT_MM, S_DIVQ, S_WAIT_Q,
        S_FIN2, S_GCD_TEST, S_WAIT_G, S_WAIT_RN, S_WAIT_RD, S_WAIT_DM,
        S_WAIT_TG, S_WAIT_P, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_red, n_red;
    logic   r_ov, n_ov;

    always_comb begin
        n_state    = r_state;
        n_red      = r_red;
        n_ov       = r_ov & ~i_ready;
        o_cmd.op   = rrr_pkg::DP_NOP;
        o_cmd.code = rrr_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = rrr_pkg::DP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_EMIT;
                if (i_stat.d_zero) begin
                    o_cmd.op   = rrr_pkg::DP_ERR;
                    o_cmd.code = rrr_pkg::ST_BAD_ARG;
                end else if (i_stat.t_zero) begin
                    if (i_stat.dm_fixed) begin
                        o_cmd.op   = rrr_pkg::DP_ERR;
                        o_cmd.code = rrr_pkg::ST_MISMATCH;
                    end else if (i_stat.dm_reduce && !i_stat.d_neg) begin
                        o_cmd.op = rrr_pkg::DP_GCD_RED;
                        n_red    = 1'b1;
                        n_state  = S_GCD_TEST;
                    end else begin
                        o_cmd.op = rrr_pkg::DP_PASS;
                    end
                end else if (i_stat.d_eq_t) begin
                    o_cmd.op = rrr_pkg::DP_PASS;
                end else if (i_stat.n_zero) begin
                    o_cmd.op = rrr_pkg::DP_ZERO;
                end else if (i_stat.d_neg) begin
                    o_cmd.op = rrr_pkg::DP_MUL_AD;
                    n_state  = S_WAIT_MA;
                end else begin
                    o_cmd.op = rrr_pkg::DP_SET_A;
                    n_state  = S_SCALE;
                end
            end
            S_WAIT_MA: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = rrr_pkg::DP_SAVE_A;
                    n_state  = S_SCALE;
                end
            end
            S_SCALE: begin
                if (i_stat.t_neg) begin
                    o_cmd.op = rrr_pkg::DP_MUL_M;
                    n_state  = S_WAIT_MM;
                end else begin
                    o_cmd.op = rrr_pkg::DP_GCD_SCL;
                    n_red    = 1'b0;
                    n_state  = S_GCD_TEST;
                end
            end
            S_WAIT_MM: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = rrr_pkg::DP_SAVE_M;
                    n_state  = S_DIVQ;
                end
            end
            S_DIVQ: begin
                o_cmd.op = rrr_pkg::DP_DIV_Q;
                n_state  = S_WAIT_Q;
            end
            S_WAIT_Q: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rrr_pkg::DP_FIN1;
                    n_state  = S_FIN2;
                end
            end
            S_FIN2: begin
                o_cmd.op = rrr_pkg::DP_FIN2;
                n_state  = S_EMIT;
            end
            S_GCD_TEST: begin
                if (!i_stat.gb_zero) begin
                    o_cmd.op = rrr_pkg::DP_GCD_DIV;
                    n_state  = S_WAIT_G;
                end else if (r_red) begin
                    o_cmd.op = rrr_pkg::DP_RED_N;
                    n_state  = S_WAIT_RN;
                end else if (i_stat.a_hi_nz) begin
                    o_cmd.op   = rrr_pkg::DP_ERR;
                    o_cmd.code = rrr_pkg::ST_OVERFLOW;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.op = rrr_pkg::DP_DIV_M;
                    n_state  = S_WAIT_DM;
                end
            end
            S_WAIT_G: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rrr_pkg::DP_GCD_NEXT;
                    n_state  = S_GCD_TEST;
                end
            end
            S_WAIT_RN: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rrr_pkg::DP_RED_D;
                    n_state  = S_WAIT_RD;
                end
            end
            S_WAIT_RD: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rrr_pkg::DP_RED_SAVE;
                    n_state  = S_EMIT;
                end
            end
            S_WAIT_DM: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rrr_pkg::DP_DIV_TG;
                    n_state  = S_WAIT_TG;
                end
            end
            S_WAIT_TG: begin
                if (i_stat.div_done) begin
                    o_cmd.op = rrr_pkg::DP_MUL_P;
                    n_state  = S_WAIT_P;
                end
            end
            S_WAIT_P: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = rrr_pkg::DP_SAVE_P;
                    n_state  = S_DIVQ;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_ready) begin
                    o_cmd.op = rrr_pkg::DP_EMIT;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_red   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_red   <= n_red;
            r_ov    <= n_ov;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;

`ifndef ASSERT_OFF
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == rrr_pkg::DP_EMIT) |=> o_valid)
        else $error("emitted result not presented");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == rrr_pkg::DP_EMIT) |-> (!r_ov || i_ready))
        else $error("result overwritten before it was taken");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item accepted while one is in flight");
`endif

endmodule

[rtl/core/rational_rescale_round_unit.sv]
// rational_rescale_round_unit: top level of the rational rescale and round block
// depends on rrr_pkg, rrr_ctrl, rrr_datapath (which holds rrr_mul and rrr_div)
// errors found at the first check and pass-through reach o_valid without the multiplier
//   or divider; a negative target adds a multiply and a wide divide; each Euclid
//   remainder step on the shared narrow divider adds to the gcd paths
// throughput: one item in flight; the next item is taken while a result waits
// reset: synchronous active-low i_rst_n clears the sequencer and the result register
module rational_rescale_round_unit #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [63:0] i_in_num,
    input  logic signed [63:0] i_in_denom,
    input  logic signed [63:0] i_target_denom,
    input  logic [1:0]         i_denom_mode,
    input  logic [2:0]         i_round_mode,
    // result item channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_out_num,
    output logic signed [63:0] o_out_denom,
    output logic [2:0]         o_status
);

    // command and status between sequencer and datapath
    rrr_pkg::t_cmd  cmd;
    rrr_pkg::t_stat stat;

    // sequencer: decides the path per item and waits on the shared units
    rrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: operands, 4-step multiplier, bit-serial divider, rounding
    rrr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_num       (i_in_num),
        .i_in_denom     (i_in_denom),
        .i_target_denom (i_target_denom),
        .i_denom_mode   (i_denom_mode),
        .i_round_mode   (i_round_mode),
        .o_stat         (stat),
        .o_out_num      (o_out_num),
        .o_out_denom    (o_out_denom),
        .o_status       (o_status)
    );

endmodule
